FILE: sv/ata_pkg.sv
// Shared constants, stage word type and arctangent table for the tilt angle pipeline.
package ata_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int ANGLE_BITS  = 16;
  localparam int RES_BITS    = ANGLE_BITS + 1;
  localparam int STEPS       = 32;
  localparam int STEP_W      = $clog2(STEPS);
  // samples are scaled so that a full-scale input sits at 2^45
  localparam int SCALE_SH    = 46 - SAMPLE_BITS;
  // 2^46 full scale, CORDIC gain and sqrt(2) growth, sign
  localparam int VEC_W       = 49;
  localparam int Z_W         = 32;

  localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [Z_W-1:0] ATAN_TAB [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] u;
    logic signed [VEC_W-1:0] v;
    logic [Z_W-1:0]          z;
    logic                    y_zero;
    logic                    x_neg;
  } stage_t;

endpackage

FILE: sv/ata_if.sv
// Valid/ready channel interfaces for sample words and angle words.
interface ata_in_if import ata_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_x;
  logic [SAMPLE_BITS-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

interface ata_out_if import ata_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RES_BITS-1:0] angle_turns;

  modport source (output valid, output angle_turns, input ready);
  modport sink (input valid, input angle_turns, output ready);
endinterface

FILE: sv/ata_prep.sv
// Front cell: sign-extend, scale and negate the sample, fold the left half-plane.
module ata_prep import ata_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SAMPLE_BITS-1:0] raw_x_i,
  input  logic [SAMPLE_BITS-1:0] raw_y_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output stage_t                 data_o
);

  logic                    valid_q;
  stage_t                  data_q, data_d;
  logic signed [VEC_W-1:0] xs, ys, u0, v0;

  always_comb begin
    xs = VEC_W'($signed(raw_x_i));
    ys = VEC_W'($signed(raw_y_i));
    u0 = -(xs <<< SCALE_SH);
    v0 = -(ys <<< SCALE_SH);
    data_d.y_zero = (raw_y_i == '0);
    data_d.x_neg  = raw_x_i[SAMPLE_BITS-1];
    // rotate by a half turn when the vector points left
    if (u0[VEC_W-1]) begin
      data_d.u = -u0;
      data_d.v = -v0;
      data_d.z = HALF_TURN;
    end else begin
      data_d.u = u0;
      data_d.v = v0;
      data_d.z = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: sv/ata_cell.sv
// One CORDIC vectoring cell: a single micro-rotation toward the first axis.
module ata_cell import ata_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [STEP_W-1:0] idx_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  stage_t            data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output stage_t            data_o
);

  logic                    valid_q;
  stage_t                  data_q, data_d;
  logic signed [VEC_W-1:0] du, dv;
  logic                    v_pos;

  always_comb begin
    du    = data_i.v >>> idx_i;
    dv    = data_i.u >>> idx_i;
    v_pos = !data_i.v[VEC_W-1] && (data_i.v != '0);
    data_d = data_i;
    if (v_pos) begin
      data_d.u = data_i.u + du;
      data_d.v = data_i.v - dv;
      data_d.z = data_i.z + ATAN_TAB[idx_i];
    end else begin
      data_d.u = data_i.u - du;
      data_d.v = data_i.v + dv;
      data_d.z = data_i.z - ATAN_TAB[idx_i];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: sv/ata_round.sv
// Output cell: complement the angle, round to the output grid, map zero to a full turn, apply the axis cases.
module ata_round import ata_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  stage_t              data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [RES_BITS-1:0] angle_o
);

  localparam logic [Z_W+1:0] FULL_Z    = 34'(1) << Z_W;
  localparam logic [Z_W+1:0] ROUND_ADD = 34'(1) << (Z_W - 1 - ANGLE_BITS);
  localparam logic [RES_BITS-1:0] FULL_RES = RES_BITS'(1) << ANGLE_BITS;
  localparam logic [RES_BITS-1:0] HALF_RES = RES_BITS'(1) << (ANGLE_BITS - 1);

  logic                valid_q;
  logic [RES_BITS-1:0] angle_q, angle_d, rounded;
  logic [Z_W+1:0]      sum;

  always_comb begin
    sum     = FULL_Z - {2'b00, data_i.z} + ROUND_ADD;
    rounded = RES_BITS'(sum >> (Z_W - ANGLE_BITS));
    if (data_i.y_zero) begin
      angle_d = data_i.x_neg ? FULL_RES : HALF_RES;
    end else if (rounded == '0) begin
      angle_d = FULL_RES;
    end else begin
      angle_d = rounded;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign angle_o = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      angle_q <= angle_d;
    end
  end

endmodule

FILE: sv/accel_tilt_angle.sv
// Tilt angle top level: front cell, row of CORDIC cells, rounding cell.
// An accepted sample word passes one front cell, 32 rotation cells and one
// output cell, each registered. Throughput: one word per cycle unless the
// output stalls; each cell holds one word and moves it on whenever the next
// cell is empty or emptying, so stalls fill bubbles.
// Reset clears every cell's valid bit; data registers are not reset.
module accel_tilt_angle import ata_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ata_in_if.sink    in_i,
  ata_out_if.source out_o
);

  logic   valid_w [STEPS+1];
  logic   ready_w [STEPS+1];
  stage_t data_w  [STEPS+1];

  ata_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .raw_x_i (in_i.raw_x),
    .raw_y_i (in_i.raw_y),
    .valid_o (valid_w[0]),
    .ready_i (ready_w[0]),
    .data_o  (data_w[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    ata_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (STEP_W'(k)),
      .valid_i (valid_w[k]),
      .ready_o (ready_w[k]),
      .data_i  (data_w[k]),
      .valid_o (valid_w[k+1]),
      .ready_i (ready_w[k+1]),
      .data_o  (data_w[k+1])
    );
  end

  ata_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_w[STEPS]),
    .ready_o (ready_w[STEPS]),
    .data_i  (data_w[STEPS]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .angle_o (out_o.angle_turns)
  );

endmodule

FILE: tb/tb_accel_tilt_angle.sv
// Testbench for the accelerometer tilt angle pipeline: random and edge samples, CORDIC predictor.
module tb_accel_tilt_angle;
  import ata_pkg::*;

  localparam int ROT_STEPS  = 32;
  localparam int SCALE_LOG2 = 46 - SAMPLE_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_WORDS = 450;

  localparam logic [RES_BITS-1:0] FULL_TURN = RES_BITS'(1) << ANGLE_BITS;
  localparam logic [RES_BITS-1:0] HALF_TURNS = RES_BITS'(1) << (ANGLE_BITS - 1);

  // arctangent of 2^-i in 2^-32 turn
  localparam logic [31:0] ARC_TURNS [ROT_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ata_in_if  in_ch ();
  ata_out_if out_ch ();

  accel_tilt_angle u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sample_t             sample_queue [$];
  logic [RES_BITS-1:0] angle_queue [$];

  int n_errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_directed = 0;
  int n_total = 0;
  int n_flat = 0;
  int n_full = 0;
  int cycle_count = 0;
  int tx_gap = 0;
  int tx_burst = 0;
  int rx_stall = 0;
  logic rx_hold = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [RES_BITS-1:0] tilt_angle(logic [SAMPLE_BITS-1:0] rx,
                                                      logic [SAMPLE_BITS-1:0] ry);
    longint sx, sy, u, v, du, dv, r, res;
    logic [31:0] z;
    sx = longint'(rx);
    sy = longint'(ry);
    if (rx[SAMPLE_BITS-1]) sx = sx - (longint'(1) << SAMPLE_BITS);
    if (ry[SAMPLE_BITS-1]) sy = sy - (longint'(1) << SAMPLE_BITS);
    if (sy == 0) begin
      return (sx < 0) ? FULL_TURN : HALF_TURNS;
    end
    u = -sx * (longint'(1) << SCALE_LOG2);
    v = -sy * (longint'(1) << SCALE_LOG2);
    z = '0;
    // fold the left half plane onto the right one
    if (u < 0) begin
      u = -u;
      v = -v;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v > 0) begin
        u = u + du;
        v = v - dv;
        z = z + ARC_TURNS[i];
      end else begin
        u = u - du;
        v = v + dv;
        z = z - ARC_TURNS[i];
      end
    end
    r = (longint'(1) << 32) - longint'(z);
    res = (r + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
    if (res == 0) res = longint'(1) << ANGLE_BITS;
    return res[RES_BITS-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] near_zero(int span);
    return SAMPLE_BITS'($urandom_range(2 * span) - span);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] edge_code();
    case ($urandom_range(4))
      0: return '0;
      1: return SAMPLE_BITS'(1);
      2: return '1;
      3: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      default: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    endcase
  endfunction

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int receiver_stall();
    if ($urandom_range(9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    n_errors++;
  endtask

  task automatic add_word(int x, int y);
    sample_t s;
    s.x = SAMPLE_BITS'(x);
    s.y = SAMPLE_BITS'(y);
    sample_queue.push_back(s);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_x = '0;
    in_ch.raw_y = '0;
    out_ch.ready = 1'b0;

    // axis cases, extremes and the near-full-turn corner
    add_word('h001, 'h000);
    add_word('hFFF, 'h000);
    add_word('h000, 'h000);
    add_word('h7FF, 'h000);
    add_word('h800, 'h000);
    add_word('h000, 'h001);
    add_word('h000, 'hFFF);
    add_word('h000, 'h7FF);
    add_word('h000, 'h800);
    add_word('h7FF, 'h7FF);
    add_word('h800, 'h800);
    add_word('h7FF, 'h800);
    add_word('h800, 'h7FF);
    add_word('h800, 'h001);
    add_word('h800, 'hFFF);
    add_word('h7FF, 'h001);
    add_word('h7FF, 'hFFF);
    add_word('hFFF, 'hFFF);
    add_word('h001, 'h001);
    add_word('hFFF, 'h001);
    add_word('h001, 'hFFF);
    add_word('h555, 'hAAA);
    add_word('hAAA, 'h555);
    n_directed = sample_queue.size();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) add_word($urandom_range(4095), $urandom_range(4095));
      else if (pick < 75) add_word(near_zero(8), near_zero(8));
      else if (pick < 85) add_word($urandom_range(4095), near_zero(1));
      else if (pick < 92) add_word(near_zero(1), $urandom_range(4095));
      else add_word(edge_code(), edge_code());
    end
    n_total = sample_queue.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender: hold a word until it is taken, then maybe pause
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.raw_x <= '0;
      in_ch.raw_y <= '0;
      tx_gap <= 0;
      tx_burst <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        logic [RES_BITS-1:0] want;
        want = tilt_angle(in_ch.raw_x, in_ch.raw_y);
        angle_queue.push_back(want);
        n_accepted++;
        if (in_ch.raw_y == '0) n_flat++;
        if (want == FULL_TURN) n_full++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          in_ch.valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (sample_queue.size() > 0) begin
          sample_t s;
          s = sample_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.raw_x <= s.x;
          in_ch.raw_y <= s.y;
          if (tx_burst > 0) begin
            tx_burst <= tx_burst - 1;
            tx_gap <= 0;
          end else if ($urandom_range(99) < 4) begin
            tx_burst <= $urandom_range(20, 40);
            tx_gap <= 0;
          end else begin
            tx_gap <= sender_gap();
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each angle word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (angle_queue.size() == 0) begin
          report_mismatch($sformatf("angle word %0d with nothing pending", out_ch.angle_turns));
        end else begin
          logic [RES_BITS-1:0] want;
          want = angle_queue.pop_front();
          n_checked++;
          if (out_ch.angle_turns !== want)
            report_mismatch($sformatf("angle_turns got %0d want %0d (word %0d)",
                                      out_ch.angle_turns, want, n_checked));
        end
      end
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        out_ch.ready <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else if ((cycle_count / 256) % 4 != 3 && $urandom_range(99) < 15) begin
        out_ch.ready <= 1'b0;
        rx_stall <= receiver_stall() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // back-pressure: block the output long enough to fill the pipeline
  initial begin
    while (n_accepted < n_directed + 20) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_count,
               angle_queue.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    // wait until every queued sample has come back as a checked angle word
    while (n_checked < n_total) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d sample words (%0d edge cases first), %0d angle words compared",
             n_accepted, n_directed, n_checked);
    $display("flat y axis %0d, full-turn answers %0d, one %0d-cycle output block",
             n_flat, n_full, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ata_pkg.sv
sv/ata_if.sv
sv/ata_prep.sv
sv/ata_cell.sv
sv/ata_round.sv
sv/accel_tilt_angle.sv
tb/tb_accel_tilt_angle.sv
